### design/dwfb_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// dwfb_pkg
// Shared types and constants of the widget frame builder: operation codes,
// controller states, frame bytes and the command and status groups.
// ---------------------------------------------------------------------------
package dwfb_pkg;

    localparam int OP_W        = 2;
    localparam int CH_W        = 9;
    localparam int LEVEL_W     = 9;
    localparam int NCH_W       = 10;
    localparam int COUNT_W     = 5;
    localparam int BEAT_BYTES  = 16;
    localparam int MIN_CHANNELS = 64;

    localparam logic [7:0] FRAME_START = 8'h7E;
    localparam logic [7:0] FRAME_END   = 8'hE7;
    localparam logic [7:0] LABEL_DATA  = 8'h06;

    // Widget parameter frame: 7E 04 05 00 00 00 09 01 28 E7, byte 0 lowest
    localparam logic [127:0] INIT_BEAT  = 128'h0000_0000_0000_E728_0109_0000_0005_047E;
    localparam logic [COUNT_W-1:0] INIT_COUNT = 5'd10;

    typedef enum logic [OP_W-1:0] {
        OP_SET  = 2'd0,
        OP_INIT = 2'd1,
        OP_TICK = 2'd2,
        OP_RSVD = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_INIT,
        ST_FETCH,
        ST_BEAT
    } state_t;

    typedef struct packed {
        logic mem_write;    // store the level of an accepted set word
        logic clear_step;   // zero one row of the level store
        logic frame_start;  // rewind the beat counter
        logic fetch;        // read the row of the current beat
        logic beat_load;    // load a data beat, advance the beat counter
        logic init_load;    // load the parameter frame beat
    } cmd_t;

    typedef struct packed {
        logic clear_done;
        logic set_ok;
        logic beat_last;
    } status_t;

endpackage
`default_nettype wire

### design/dwfb_datapath.sv
`default_nettype none
// ---------------------------------------------------------------------------
// dwfb_datapath
// Level store in rows of 16 bytes, channel count register, beat assembly
// and the output word register.
// ---------------------------------------------------------------------------
module dwfb_datapath #(
    parameter int MAX_CHANNELS = 512
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire dwfb_pkg::cmd_t              cmd,
    output dwfb_pkg::status_t                status,
    input  wire logic                        cfg_write,
    input  wire logic [dwfb_pkg::NCH_W-1:0]  cfg_chan_count,
    input  wire logic [dwfb_pkg::CH_W-1:0]   channel,
    input  wire logic [dwfb_pkg::LEVEL_W-1:0] level,
    output logic [63:0]                      bytes_low,
    output logic [63:0]                      bytes_high,
    output logic [dwfb_pkg::COUNT_W-1:0]     byte_count,
    output logic                             last
);
    import dwfb_pkg::*;

    localparam int ROWS      = (MAX_CHANNELS + 15) / 16;
    localparam int ROW_W     = $clog2(ROWS);
    localparam int MAX_BEATS = (MAX_CHANNELS + 5 + 15) / 16;
    localparam int BEAT_W    = $clog2(MAX_BEATS);
    localparam int J_W       = BEAT_W + 4;

    logic [15:0][7:0]    mem [ROWS];
    logic [15:0][7:0]    rdata_reg;
    logic [3:0][7:0]     tail_reg;
    logic [NCH_W-1:0]    num_ch_reg;
    logic [NCH_W-1:0]    num_ch_next;
    logic [ROW_W-1:0]    clr_row_reg;
    logic [BEAT_W-1:0]   beat_reg;
    logic [ROW_W-1:0]    rd_addr;
    logic [ROW_W-1:0]    wr_row;
    logic [J_W-1:0]      beat_base;
    logic [J_W-1:0]      n_ext;
    logic [J_W-1:0]      rem;
    logic [15:0][7:0]    beat_bytes;
    logic [63:0]         bytes_low_reg;
    logic [63:0]         bytes_high_reg;
    logic [COUNT_W-1:0]  byte_count_reg;
    logic                last_reg;

    assign wr_row    = channel[ROW_W+3:4];
    assign beat_base = {beat_reg, 4'b0000};
    assign n_ext     = J_W'(num_ch_reg);
    assign rem       = n_ext + J_W'(5) - beat_base;
    assign rd_addr   = (beat_reg < BEAT_W'(ROWS)) ? beat_reg[ROW_W-1:0] : ROW_W'(ROWS - 1);

    assign status.clear_done = (clr_row_reg == ROW_W'(ROWS - 1));
    assign status.set_ok     = ({1'b0, channel} < num_ch_reg) && !level[LEVEL_W-1];
    assign status.beat_last  = (rem <= J_W'(BEAT_BYTES));

    // clamp written channel count into the supported range
    always_comb
    begin
        if (cfg_chan_count < NCH_W'(MIN_CHANNELS))
            num_ch_next = NCH_W'(MIN_CHANNELS);
        else if (cfg_chan_count > NCH_W'(MAX_CHANNELS))
            num_ch_next = NCH_W'(MAX_CHANNELS);
        else
            num_ch_next = cfg_chan_count;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_ch_reg  <= NCH_W'(MIN_CHANNELS);
            clr_row_reg <= '0;
            beat_reg    <= '0;
        end
        else
        begin
            if (cfg_write)
                num_ch_reg <= num_ch_next;
            if (cmd.clear_step)
                clr_row_reg <= clr_row_reg + 1'b1;
            if (cmd.frame_start)
                beat_reg <= '0;
            else if (cmd.beat_load)
                beat_reg <= beat_reg + 1'b1;
        end
    end

    // level store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.clear_step)
            mem[clr_row_reg] <= '0;
        else if (cmd.mem_write)
            mem[wr_row][channel[3:0]] <= level[7:0];
        if (cmd.fetch)
            rdata_reg <= mem[rd_addr];
    end

    // lane i carries frame byte 16*beat + i
    always_comb
    begin
        logic [J_W-1:0] j;
        beat_bytes = '0;
        for (int i = 0; i < BEAT_BYTES; i++)
        begin
            j = beat_base + J_W'(i);
            if (j < J_W'(4))
            begin
                case (i)
                    0:       beat_bytes[i] = FRAME_START;
                    1:       beat_bytes[i] = LABEL_DATA;
                    2:       beat_bytes[i] = num_ch_reg[7:0];
                    default: beat_bytes[i] = {6'b000000, num_ch_reg[9:8]};
                endcase
            end
            else if (j < n_ext + J_W'(4))
            begin
                if (i >= 4)
                    beat_bytes[i] = rdata_reg[(i + 12) % 16];
                else
                    beat_bytes[i] = tail_reg[i % 4];
            end
            else if (j == n_ext + J_W'(4))
                beat_bytes[i] = FRAME_END;
            else
                beat_bytes[i] = 8'h00;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.init_load)
        begin
            bytes_low_reg  <= INIT_BEAT[63:0];
            bytes_high_reg <= INIT_BEAT[127:64];
            byte_count_reg <= INIT_COUNT;
            last_reg       <= 1'b1;
        end
        else if (cmd.beat_load)
        begin
            bytes_low_reg  <= beat_bytes[7:0];
            bytes_high_reg <= beat_bytes[15:8];
            byte_count_reg <= status.beat_last ? rem[COUNT_W-1:0] : COUNT_W'(BEAT_BYTES);
            last_reg       <= status.beat_last;
            tail_reg       <= rdata_reg[15:12];
        end
    end

    assign bytes_low  = bytes_low_reg;
    assign bytes_high = bytes_high_reg;
    assign byte_count = byte_count_reg;
    assign last       = last_reg;

endmodule
`default_nettype wire

### design/dwfb_ctrl.sv
`default_nettype none
// ---------------------------------------------------------------------------
// dwfb_ctrl
// Controller: store clearing after reset, operation decode, changed flag,
// beat sequencing and output valid.
// ---------------------------------------------------------------------------
module dwfb_ctrl (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire logic [dwfb_pkg::OP_W-1:0] op,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output dwfb_pkg::cmd_t                 cmd,
    input  wire dwfb_pkg::status_t         status
);
    import dwfb_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   dirty_reg;
    logic   dirty_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   slot_free;

    assign slot_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            dirty_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            dirty_reg     <= dirty_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        dirty_next = dirty_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (status.clear_done)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                // ready is always high here, so valid alone accepts the word
                in_ready = 1'b1;
                if (in_valid)
                begin
                    case (op)
                        OP_SET:
                        begin
                            // drop out-of-range writes
                            cmd.mem_write = status.set_ok;
                            if (status.set_ok)
                                dirty_next = 1'b1;
                        end
                        OP_INIT:
                            state_next = ST_INIT;
                        OP_TICK:
                        begin
                            if (dirty_reg)
                            begin
                                dirty_next      = 1'b0;
                                cmd.frame_start = 1'b1;
                                state_next      = ST_FETCH;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_INIT:
            begin
                if (slot_free)
                begin
                    cmd.init_load = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_FETCH:
            begin
                cmd.fetch  = 1'b1;
                state_next = ST_BEAT;
            end
            ST_BEAT:
            begin
                if (slot_free)
                begin
                    cmd.beat_load = 1'b1;
                    state_next    = status.beat_last ? ST_IDLE : ST_FETCH;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        if (cmd.init_load || cmd.beat_load)
            out_valid_next = 1'b1;
    end

    assign out_valid = out_valid_reg;

endmodule
`default_nettype wire

### design/dmx_widget_frame_builder_core.sv
`default_nettype none
// ---------------------------------------------------------------------------
// dmx_widget_frame_builder_core
// Builds serial widget frames from a store of channel levels.
// ---------------------------------------------------------------------------
// Usage:
//   Input words (op, channel, level) enter on in_valid/in_ready. A set word
//   stores one level (dropped if channel is not below the channel count or
//   level > 255) and marks the store changed. An init word emits the 10-byte
//   parameter frame. A tick word emits a data frame (7E 06, length LSB/MSB,
//   levels, E7) only when the store changed since the last data frame.
//   Output words carry up to 16 frame bytes, byte 0 in bytes_low[7:0], with
//   byte_count and last; unused lanes are zero.
// Timing:
//   A set word is stored as it is accepted. An init word moves to ST_INIT,
//   which loads the parameter frame beat once the output slot is free. Each
//   data frame beat is a row read of the level store (ST_FETCH), then a beat
//   load (ST_BEAT) once the slot is free, up to 33 beats by default;
//   the block takes no new word until the cycle after the last beat is
//   loaded. A stalled receiver holds the output word and the sequencer waits.
// Reset:
//   After rst_n the level store is cleared one 16-byte row per cycle, all
//   MAX_CHANNELS/16 rounded up rows (32 at the default), with in_ready low.
//   Channel count resets to 64; cfg_chan_count writes are clamped to
//   64..MAX_CHANNELS and are taken any time cfg_ready is high (always).
// ---------------------------------------------------------------------------
module dmx_widget_frame_builder_core #(
    parameter int MAX_CHANNELS = 512
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [dwfb_pkg::NCH_W-1:0]   cfg_chan_count,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic [dwfb_pkg::OP_W-1:0]    op,
    input  wire logic [dwfb_pkg::CH_W-1:0]    channel,
    input  wire logic [dwfb_pkg::LEVEL_W-1:0] level,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic [63:0]                       bytes_low,
    output logic [63:0]                       bytes_high,
    output logic [dwfb_pkg::COUNT_W-1:0]      byte_count,
    output logic                              last
);
    import dwfb_pkg::*;

    cmd_t    cmd;
    status_t status;

    // configuration register always takes a write word
    assign cfg_ready = 1'b1;

    dwfb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .op        (op),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .status    (status)
    );

    dwfb_datapath #(
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .status           (status),
        .cfg_write        (cfg_valid && cfg_ready),
        .cfg_chan_count   (cfg_chan_count),
        .channel          (channel),
        .level            (level),
        .bytes_low        (bytes_low),
        .bytes_high       (bytes_high),
        .byte_count       (byte_count),
        .last             (last)
    );

    // never overwrite an output word that is still waiting
    a_load_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.beat_load || cmd.init_load) |-> (!out_valid || out_ready))
        else $error("beat loaded over a pending output word");

    // the parameter frame is one full-frame beat of 10 bytes
    a_init_beat: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.init_load |=> (out_valid && last && byte_count == INIT_COUNT))
        else $error("parameter frame beat malformed");

    // input is held off while a data frame is being built
    a_frame_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.frame_start |=> !in_ready)
        else $error("input taken during data frame");

    // store writes and beat reads never overlap
    a_no_write_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mem_write |-> (!cmd.fetch && !cmd.beat_load && !cmd.clear_step))
        else $error("level write collides with frame read or clear");

endmodule
`default_nettype wire
